// File: rtl/core/mhpq_pkg.sv
// Package for the binary max-heap priority queue.
// Holds the capacity constants, request and result types, and code names.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Child links are one bit wider than an address, so 2*pos+1 never wraps.
    localparam int LINK_W   = ADDR_W + 1;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;
    localparam logic signed [31:0] ZERO_VALUE  = 32'sd0;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic [1:0]         status;
        logic [6:0]         count;
    } t_res;

    // Operand selection for the shared key comparator.
    typedef enum logic [1:0] {
        CMP_UP    = 2'd0,  // held key against parent entry
        CMP_CHILD = 2'd1,  // right child against left child
        CMP_DOWN  = 2'd2   // chosen child against held key
    } t_cmp_sel;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

// File: rtl/core/mhpq_cmp.sv
// Shared signed key comparator for the heap sequencer.
// Selects one operand pair and reports strict greater-than; uses mhpq_pkg.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  t_cmp_sel           i_sel,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_rd_a,
    input  logic signed [31:0] i_rd_b,
    input  logic signed [31:0] i_cand,
    output logic               o_gt
);

    logic signed [31:0] w_lhs;
    logic signed [31:0] w_rhs;

    always_comb begin
        unique case (i_sel)
            CMP_UP: begin
                w_lhs = i_key;
                w_rhs = i_rd_a;
            end
            CMP_CHILD: begin
                w_lhs = i_rd_b;
                w_rhs = i_rd_a;
            end
            CMP_DOWN: begin
                w_lhs = i_cand;
                w_rhs = i_key;
            end
            default: begin
                w_lhs = i_key;
                w_rhs = i_key;
            end
        endcase
    end

    assign o_gt = (w_lhs > w_rhs);

endmodule

// File: rtl/core/mhpq_engine.sv
// Heap sequencer: entry store, entry count and the sift-up/sift-down control.
// Uses mhpq_pkg and the shared comparator mhpq_cmp.
module mhpq_engine
    import mhpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_req      i_req,
    input  logic      i_take,
    output t_eng_stat o_stat,
    output t_res      o_res
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_UP_RD  = 10'b00_0000_0010,
        S_UP_CMP = 10'b00_0000_0100,
        S_EX_RD  = 10'b00_0000_1000,
        S_EX_LD  = 10'b00_0001_0000,
        S_DN_RD  = 10'b00_0010_0000,
        S_DN_C1  = 10'b00_0100_0000,
        S_DN_C2  = 10'b00_1000_0000,
        S_FIN    = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [ADDR_W-1:0]     r_cand_pos, n_cand_pos;
    logic signed [31:0]    r_key, n_key;
    logic signed [31:0]    r_cand, n_cand;
    logic signed [31:0]    r_max, n_max;
    logic [1:0]            r_status, n_status;
    logic                  r_rvalid, n_rvalid;

    logic signed [31:0]    r_mem [CAPACITY];
    logic signed [31:0]    r_rd_a;
    logic signed [31:0]    r_rd_b;
    logic [ADDR_W-1:0]     w_ra_a;
    logic [ADDR_W-1:0]     w_ra_b;
    logic                  w_we;
    logic [ADDR_W-1:0]     w_wa;
    logic signed [31:0]    w_wd;

    t_cmp_sel              w_sel;
    logic                  w_gt;
    logic [ADDR_W-1:0]     w_parent;
    logic [LINK_W-1:0]     w_left;
    logic [LINK_W-1:0]     w_right;
    logic [LINK_W-1:0]     w_n;

    assign w_parent = (r_pos - ADDR_W'(1)) >> 1;
    assign w_left   = {r_pos, 1'b1};
    assign w_right  = w_left + LINK_W'(1);
    assign w_n      = LINK_W'(r_count);

    mhpq_cmp u_cmp (
        .i_sel  (w_sel),
        .i_key  (r_key),
        .i_rd_a (r_rd_a),
        .i_rd_b (r_rd_b),
        .i_cand (r_cand),
        .o_gt   (w_gt)
    );

    // Entry store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_a <= r_mem[w_ra_a];
        r_rd_b <= r_mem[w_ra_b];
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_cand_pos = r_cand_pos;
        n_key      = r_key;
        n_cand     = r_cand;
        n_max      = r_max;
        n_status   = r_status;
        n_rvalid   = r_rvalid;
        w_ra_a     = '0;
        w_ra_b     = '0;
        w_we       = 1'b0;
        w_wa       = r_pos;
        w_wd       = r_key;
        w_sel      = CMP_UP;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_max    = ZERO_VALUE;
                    if (i_req.func == FUNC_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_key   = i_req.value;
                            n_pos   = ADDR_W'(r_count);
                            n_count = r_count + CNT_W'(1);
                            n_state = (r_count == '0) ? S_FIN : S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_max    = EMPTY_VALUE;
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = S_EX_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                w_ra_a  = w_parent;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                w_sel = CMP_UP;
                if (w_gt) begin
                    // Parent moves down into the hole; the key climbs.
                    w_we    = 1'b1;
                    w_wd    = r_rd_a;
                    n_pos   = w_parent;
                    n_state = (w_parent == '0) ? S_FIN : S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EX_RD: begin
                w_ra_a  = '0;
                w_ra_b  = ADDR_W'(r_count);
                n_state = S_EX_LD;
            end
            S_EX_LD: begin
                n_max   = r_rd_a;
                n_key   = r_rd_b;
                n_pos   = '0;
                n_state = (r_count == '0) ? S_RESP : S_DN_RD;
            end
            S_DN_RD: begin
                if (w_left >= w_n) begin
                    n_state = S_FIN;
                end else begin
                    w_ra_a   = w_left[ADDR_W-1:0];
                    w_ra_b   = w_right[ADDR_W-1:0];
                    n_rvalid = (w_right < w_n);
                    n_state  = S_DN_C1;
                end
            end
            S_DN_C1: begin
                w_sel = CMP_CHILD;
                if (r_rvalid && w_gt) begin
                    n_cand     = r_rd_b;
                    n_cand_pos = w_right[ADDR_W-1:0];
                end else begin
                    n_cand     = r_rd_a;
                    n_cand_pos = w_left[ADDR_W-1:0];
                end
                n_state = S_DN_C2;
            end
            S_DN_C2: begin
                w_sel = CMP_DOWN;
                if (w_gt) begin
                    // Larger child moves up into the hole; the key sinks.
                    w_we    = 1'b1;
                    w_wd    = r_cand;
                    n_pos   = r_cand_pos;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_we    = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos      <= n_pos;
        r_cand_pos <= n_cand_pos;
        r_key      <= n_key;
        r_cand     <= n_cand;
        r_max      <= n_max;
        r_status   <= n_status;
        r_rvalid   <= n_rvalid;
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_RESP) && i_take;
    assign o_res.max_value = r_max;
    assign o_res.status    = r_status;
    assign o_res.count     = 7'(r_count);

`ifndef SYNTHESIS
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE && i_start) |=> $stable(r_count))
        else $error("entry count changed outside request acceptance");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_UP_CMP || r_state == S_DN_C2 || r_state == S_FIN))
        else $error("store written outside a sift step");

    a_up_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD) |-> (r_pos != '0))
        else $error("sift up started at the root");

    a_resp_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && i_take) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule

// File: rtl/core/max_heap_priority_queue_top.sv
// Insert sifts up level by level (read parent, then compare and move), then stores the key.
// Extract loads the root and last entry, then, if entries remain, sifts down level by level
// (read children, pick, compare) over at most five levels and stores the key where it stops.
// The rate is set by the single sequencer and its one shared key comparator: a new
// transaction is taken only once the last one has left the sequencer.
// A full-heap insert or empty-heap extract goes straight to its response without a sift.
// Synchronous active-low reset empties the heap; store contents are left as they are.
module max_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_data
);

    // The heap handles one request transaction at a time. The input channel is
    // stalled whenever the sequencer is not idle, so a new transaction is taken
    // only once the previous one has produced its result.
    t_eng_stat w_stat;
    t_res      w_res;
    logic      w_in_acc;
    logic      w_take;

    logic r_out_valid;
    t_res r_out_data;

    assign o_in_stall = !w_stat.idle;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // The output register can take a new result when it is empty or when its
    // current result transaction completes in this cycle. This lets the engine
    // start on the next request while a finished result still waits downstream.
    assign w_take = !r_out_valid || !i_out_stall;

    mhpq_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_req   (i_in_data),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    // Result register. The payload holds while the valid flag is up and the
    // downstream side stalls, since a new result is loaded only on w_take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_stat.done) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
